// ===== src/mono_page_frame_buffer_macros.svh =====
// assertion macros for the frame buffer
`ifndef MONO_PAGE_FRAME_BUFFER_MACROS_SVH
`define MONO_PAGE_FRAME_BUFFER_MACROS_SVH
// check that a property holds on every clock edge outside reset
`define MPFB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check a property that also holds during reset
`define MPFB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== src/mpfb_pkg.sv =====
package mpfb_pkg;

  typedef enum logic [2:0] {
    OP_POINT   = 3'd0,
    OP_FILL    = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_BLIT    = 3'd3,
    OP_REFRESH = 3'd4
  } opcode_t;

  localparam logic [7:0] CMD_PAGE     = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW  = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH = 8'h10;
  localparam logic [7:0] TOP_BIT      = 8'h01;

  localparam int unsigned IN_BITS = 66;
  localparam int unsigned IN_BYTES_BITS = 72;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_RD    = 7'b0000100,
    ST_WR    = 7'b0001000,
    ST_FILL  = 7'b0010000,
    ST_FWR   = 7'b0100000,
    ST_REF   = 7'b1000000
  } state_t;

endpackage

// ===== src/mono_page_frame_buffer.sv =====
// Monochrome page frame buffer. Commands arrive one beat at a time on the in_ channel; the
// store is one byte memory of COLUMNS x PAGES entries with one write and one read port
// (column-major, one byte per column of an 8-row page). A point beat is accepted, then its
// byte is read, then modified and written. A blit beat that draws reads and writes the byte
// of its 8 rows, or two bytes across a page boundary; one that draws nothing, or lands on a
// column outside the store, ends on acceptance. A refresh beat loads a command byte into the
// output register, or reads the store for a data byte that then moves into that register.
// Clear writes all COLUMNS*PAGES entries in turn and a fill reads and writes each store byte
// of the rectangle in turn. New beats are held off during these and while a result waits in the
// output register and out_tready is low. After reset a clearing pass over all COLUMNS*PAGES
// entries runs before the first beat is accepted. Only refresh beats give an out_ beat.
`include "mono_page_frame_buffer_macros.svh"
module mono_page_frame_buffer
  import mpfb_pkg::*;
#(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned PAGES   = 8,
  parameter int unsigned ROWS    = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[2:0], x[10:3], y[18:11], x_end[26:19], y_end[34:27], pattern[42:35],
  // mode[43], pic_width[51:44], pic_height[59:52], first_byte[60], zero fill above
  input  logic [71:0] in_tdata,
  input  logic        out_tready,
  output logic        out_tvalid,
  // out_byte[7:0], is_data[8], end_of_frame[9], zero fill above
  output logic [15:0] out_tdata
);

  localparam int unsigned DEPTH = COLUMNS * PAGES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned POSW  = $clog2(COLUMNS + 3);

  // input fields
  logic [2:0] f_op;
  logic [7:0] f_x, f_y, f_xe, f_ye, f_pat, f_pw, f_ph;
  logic       f_mode, f_first;
  assign f_op    = in_tdata[2:0];
  assign f_x     = in_tdata[10:3];
  assign f_y     = in_tdata[18:11];
  assign f_xe    = in_tdata[26:19];
  assign f_ye    = in_tdata[34:27];
  assign f_pat   = in_tdata[42:35];
  assign f_mode  = in_tdata[43];
  assign f_pw    = in_tdata[51:44];
  assign f_ph    = in_tdata[59:52];
  assign f_first = in_tdata[60];

  // the store
  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_r;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  // control registers
  state_t        state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [7:0]    mset_r, mset_nxt;    // bits to modify
  logic [7:0]    mval_r, mval_nxt;    // new bit values
  logic [8:0]    fcol_r, fcol_nxt;
  logic [5:0]    fpg_r, fpg_nxt;
  logic [8:0]    fxe_r, fxe_nxt;
  logic [8:0]    fy0_r, fy0_nxt, fye_r, fye_nxt;
  logic [PW-1:0] rpage_r, rpage_nxt;
  logic [POSW-1:0] rpos_r, rpos_nxt;
  logic [7:0]    bcol_r, bcol_nxt;
  logic [4:0]    bband_r, bband_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [7:0]    obyte_r, obyte_nxt;
  logic          odata_r, odata_nxt, oeof_r, oeof_nxt;
  logic          rsel_r, rsel_nxt;    // output byte comes from memory

  // fill row mask for page fpg over rows fy0..fye
  function automatic logic [7:0] row_mask(input logic [5:0] pg, input logic [8:0] y0,
                                          input logic [8:0] y1);
    logic [8:0] r;
    logic [7:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) begin
      r = {pg, 3'(k)};
      m[k] = (r >= y0) && (r <= y1);
    end
    return m;
  endfunction

  logic [8:0]  pix_col;
  logic [8:0]  brow0;
  logic [7:0]  bmask, bval;
  logic [15:0] brot;
  logic [4:0]  bband_eff;
  logic [7:0]  bcol_eff;
  logic [8:0]  fxe_c, fye_c;

  always_comb begin
    state_nxt = state_r; addr_nxt = addr_r; mset_nxt = mset_r; mval_nxt = mval_r;
    fcol_nxt = fcol_r; fpg_nxt = fpg_r; fxe_nxt = fxe_r;
    fy0_nxt = fy0_r; fye_nxt = fye_r;
    rpage_nxt = rpage_r; rpos_nxt = rpos_r; bcol_nxt = bcol_r; bband_nxt = bband_r;
    ovalid_nxt = ovalid_r; obyte_nxt = obyte_r; odata_nxt = odata_r; oeof_nxt = oeof_r;
    rsel_nxt = rsel_r;
    we = 1'b0; waddr = addr_r; wdata = (rdata_r & ~mset_r) | (mval_r & mset_r);
    raddr = addr_r;
    in_tready = 1'b0;
    pix_col = '0; bmask = '0; bval = '0; brot = '0; bband_eff = bband_r; bcol_eff = bcol_r;
    fxe_c = '0; fye_c = '0; brow0 = '0;

    // output register
    if (ovalid_r && !rsel_r && out_tready) ovalid_nxt = 1'b0;
    if (rsel_r) begin
      obyte_nxt = rdata_r;
      rsel_nxt  = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        we = 1'b1; wdata = '0;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == AW'(DEPTH - 1)) begin
          addr_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = !ovalid_r || out_tready;
        if (in_tvalid && in_tready) begin
          unique case (f_op)
            OP_POINT: begin
              if ({1'b0, f_x} < 9'(COLUMNS) && {1'b0, f_y} < 9'(ROWS)
                  && {4'd0, f_y[7:3]} < 9'(PAGES)) begin
                addr_nxt = AW'(32'(f_x) * PAGES + 32'(f_y[7:3]));
                mset_nxt = TOP_BIT << f_y[2:0];
                mval_nxt = f_mode ? 8'hFF : 8'h00;
                state_nxt = ST_RD;
              end
            end
            OP_FILL: begin
              fxe_c = ({1'b0, f_xe} > 9'(COLUMNS - 1)) ? 9'(COLUMNS - 1) : {1'b0, f_xe};
              fye_c = ({1'b0, f_ye} > 9'(ROWS - 1)) ? 9'(ROWS - 1) : {1'b0, f_ye};
              if ({1'b0, f_x} <= fxe_c && {1'b0, f_y} <= fye_c) begin
                fxe_nxt = fxe_c;
                fy0_nxt = {1'b0, f_y}; fye_nxt = fye_c;
                fcol_nxt = {1'b0, f_x}; fpg_nxt = {1'b0, f_y[7:3]};
                mval_nxt = f_mode ? 8'hFF : 8'h00;
                state_nxt = ST_FILL;
              end
            end
            OP_CLEAR: begin
              addr_nxt = '0;
              state_nxt = ST_CLEAR;
            end
            OP_BLIT: begin
              if (f_first) begin
                bband_eff = '0; bcol_eff = '0;
              end
              bband_nxt = bband_eff; bcol_nxt = bcol_eff;
              if (f_pw != 8'd0 && bband_eff < f_ph[7:3]) begin
                pix_col = {1'b0, f_x + bcol_eff};
                brow0 = {1'b0, f_y + {bband_eff, 3'b000}};
                for (int k = 0; k < 8; k++) begin
                  bval[k] = (f_pat[k] == f_mode);
                end
                // line the picture bits up with the row position inside a store byte
                brot = {bval, bval} << brow0[2:0];
                addr_nxt = '0;
                mset_nxt = '0;
                // drawn as a one-column, 8-row fill; rows may straddle two pages and
                // rows past 255 wrap into page 0 through the sixth page bit
                fxe_nxt = pix_col;
                fy0_nxt = brow0; fye_nxt = brow0 + 9'd7;
                fcol_nxt = pix_col; fpg_nxt = {1'b0, brow0[7:3]};
                mval_nxt = brot[15:8];
                if (pix_col < 9'(COLUMNS)) state_nxt = ST_FILL;
                if (9'(bcol_eff) + 9'd1 >= {1'b0, f_pw}) begin
                  bcol_nxt = '0;
                  if (bband_eff < 5'd31) bband_nxt = bband_eff + 5'd1;
                end else begin
                  bcol_nxt = bcol_eff + 8'd1;
                end
              end
              bmask = '0;
            end
            OP_REFRESH: begin
              ovalid_nxt = 1'b1; odata_nxt = 1'b0; oeof_nxt = 1'b0;
              if (rpos_r == POSW'(0)) obyte_nxt = CMD_PAGE + 8'(rpage_r);
              else if (rpos_r == POSW'(1)) obyte_nxt = CMD_COL_LOW;
              else if (rpos_r == POSW'(2)) obyte_nxt = CMD_COL_HIGH;
              else begin
                raddr = AW'(32'(rpos_r - POSW'(3)) * PAGES + 32'(rpage_r));
                rsel_nxt = 1'b1; odata_nxt = 1'b1;
                oeof_nxt = (rpos_r == POSW'(COLUMNS + 2)) && (rpage_r == PW'(PAGES - 1));
                state_nxt = ST_REF;
              end
              if (rpos_r >= POSW'(COLUMNS + 2)) begin
                rpos_nxt = '0;
                rpage_nxt = (32'(rpage_r) + 1 >= PAGES) ? '0 : rpage_r + 1'b1;
              end else begin
                rpos_nxt = rpos_r + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD: state_nxt = ST_WR;
      ST_WR: begin
        we = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_FILL: begin
        // each store byte is read here and written in ST_FWR; rows and pages outside the store are masked off
        addr_nxt = AW'(32'(fcol_r[7:0]) * PAGES + 32'(fpg_r[4:0]));
        raddr = addr_nxt;
        bmask = row_mask(fpg_r, fy0_r, fye_r);
        for (int k = 0; k < 8; k++) begin
          if (32'({fpg_r[4:0], 3'(k)}) >= ROWS) bmask[k] = 1'b0;
        end
        if (32'(fpg_r[4:0]) >= PAGES) bmask = '0;
        mset_nxt = bmask;
        state_nxt = ST_FWR;
        if (fcol_r >= 9'(COLUMNS)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FWR: begin
        we = |mset_r;
        state_nxt = ST_FILL;
        if ({fpg_r, 3'b111} >= fye_r) begin
          fpg_nxt = {1'b0, fy0_r[7:3]};
          fcol_nxt = fcol_r + 9'd1;
          if (fcol_r >= fxe_r) state_nxt = ST_IDLE;
        end else begin
          fpg_nxt = fpg_r + 6'd1;
        end
      end
      ST_REF: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR; addr_r <= '0; rpage_r <= '0; rpos_r <= '0;
      bcol_r <= '0; bband_r <= '0; ovalid_r <= 1'b0; rsel_r <= 1'b0;
    end else begin
      state_r <= state_nxt; addr_r <= addr_nxt; rpage_r <= rpage_nxt; rpos_r <= rpos_nxt;
      bcol_r <= bcol_nxt; bband_r <= bband_nxt; ovalid_r <= ovalid_nxt; rsel_r <= rsel_nxt;
    end
    mset_r <= mset_nxt; mval_r <= mval_nxt; fcol_r <= fcol_nxt; fpg_r <= fpg_nxt;
    fxe_r <= fxe_nxt; fy0_r <= fy0_nxt; fye_r <= fye_nxt;
    obyte_r <= obyte_nxt; odata_r <= odata_nxt; oeof_r <= oeof_nxt;
  end

  assign out_tvalid = ovalid_r && !rsel_r;
  assign out_tdata  = {6'd0, oeof_r, odata_r, rsel_r ? rdata_r : obyte_r};

  // checks
  `MPFB_ASSERT(a_eof_data, clk, rst_n, out_tvalid && out_tdata[9] |-> out_tdata[8],
               "end of frame on a command byte")
  `MPFB_ASSERT(a_no_take_busy, clk, rst_n, in_tready |-> state_r == ST_IDLE,
               "beat taken while the store is busy")
  `MPFB_ASSERT(a_rpos_range, clk, rst_n, 32'(rpos_r) <= COLUMNS + 2,
               "refresh position past the page end")
  `MPFB_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> state_r == ST_CLEAR,
                      "reset did not start the clearing pass")

endmodule
